// ----- hw/rtl/lrut_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tag store package
// Command and status bundles between controller and datapath, plus the
// elaboration-time helper used by the datapath.
// ----------------------------------------------------------------------------
package lrut_pkg;

  // Width of the entry index field on the result port
  localparam int IDX_OUT_W = 10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;       // capture request and issue the set row read
    logic look;         // compare tags, load the time candidates
    logic reduce_step;  // one halving step of the oldest-entry search
    logic commit;       // write rows back and load the result register
    logic clr_step;     // clear one row of the state memory
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic look_hit;     // a valid entry with matching tag is in the row
    logic reduce_last;  // this halving step is the final one
    logic clear_last;   // the clearing pass is on its final row
  } status_t;

  // Count trailing zero bits (at most 31) of a positive count
  function automatic int trailing_zeros(input int value);
    int   n;
    int   v;
    logic stop;
    n    = 0;
    v    = value;
    stop = 1'b0;
    for (int i = 0; i < 31; i++) begin
      if (!stop) begin
        if (v[0]) begin
          stop = 1'b1;
        end else begin
          v = v >> 1;
          n = n + 1;
        end
      end
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/lrut_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module lrut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/lrut_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tag store controller
// Sequences clearing, lookup, oldest-entry search and write-back, and owns
// the request handshake and the result valid flag.
// ----------------------------------------------------------------------------
module lrut_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lrut_pkg::status_t status,
  output lrut_pkg::cmd_t    cmd
);

  import lrut_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_REDUCE,
    ST_WRITE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Result register can take a new value this cycle
  assign out_free = !out_valid || !out_stall;

  // Take requests only when idle
  assign in_stall = (state != ST_IDLE);

  // Commands and next state
  always_comb begin
    cmd             = '0;
    state_next      = state;
    cmd.accept      = (state == ST_IDLE) && in_valid;
    cmd.look        = (state == ST_LOOK);
    cmd.reduce_step = (state == ST_REDUCE);
    cmd.commit      = (state == ST_WRITE) && out_free;
    cmd.clr_step    = (state == ST_CLEAR);
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = status.look_hit ? ST_WRITE : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (status.reduce_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_to_look : assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_LOOK)
    else $error("accepted request did not move to lookup");

  a_reduce_to_write : assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE) && status.reduce_last |=> state == ST_WRITE)
    else $error("search end did not lead to write-back");

  a_commit_result : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid && (state == ST_IDLE))
    else $error("write-back did not present a result");

  a_no_accept_clear : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) && !status.clear_last |=> !cmd.accept)
    else $error("request accepted during clearing pass");
`endif

endmodule

// ----- hw/rtl/lrut_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU tag store datapath
// Address split, set row memories, tag compare, oldest-entry search tree
// and the result register.
// ----------------------------------------------------------------------------
module lrut_dp #(
  parameter int ADDR_BITS   = 32,
  parameter int OFFSET_BITS = 2,
  parameter int WAYS        = 4,
  parameter int SET_COUNT   = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lrut_pkg::cmd_t                 cmd,
  output lrut_pkg::status_t              status,
  input  logic [31:0]                    address,
  input  logic [31:0]                    now_time,
  output logic                           hit,
  output logic [lrut_pkg::IDX_OUT_W-1:0] entry_index
);

  import lrut_pkg::*;

  localparam int SET_BITS = trailing_zeros(SET_COUNT);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int ROW_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int SLOTS    = 1 << OFFSET_BITS;
  localparam int SET_SIZE = WAYS * SLOTS;
  localparam int LEVELS   = $clog2(SET_SIZE);
  localparam int PAD      = 1 << LEVELS;
  localparam int K_W      = (LEVELS > 0) ? LEVELS : 1;
  localparam int RC_W     = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;
  localparam int TSHIFT   = OFFSET_BITS + SET_BITS;
  localparam int TAG_W    = (ADDR_BITS > TSHIFT) ? (ADDR_BITS - TSHIFT) : 1;
  localparam int EXT_W    = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + TSHIFT + 1;
  localparam int ST_W     = 1 + TIME_BITS;
  localparam int IDX_W    = SET_W + K_W;
  localparam logic [SET_W-1:0] SET_MASK = (SET_BITS > 0) ? '1 : '0;

  logic [EXT_W-1:0]          addr_ext;
  logic [TAG_W-1:0]          tag_in;
  logic [SET_W-1:0]          set_in;
  logic [ROW_W-1:0]          row_in;
  logic [TIME_BITS-1:0]      now_in;

  logic [TAG_W-1:0]          tag_q;
  logic [TIME_BITS-1:0]      now_q;
  logic [ROW_W-1:0]          row_q;
  logic [IDX_W-1:0]          base_q;

  logic [SET_SIZE*TAG_W-1:0] tag_rdata;
  logic [SET_SIZE*TAG_W-1:0] tag_wdata;
  logic [SET_SIZE*ST_W-1:0]  st_rdata;
  logic [SET_SIZE*ST_W-1:0]  st_wdata;
  logic [ROW_W-1:0]          st_waddr;

  logic                      hit_c;
  logic [K_W-1:0]            hit_slot_c;
  logic                      hit_q;
  logic [K_W-1:0]            hit_slot_q;

  logic [TIME_BITS-1:0]      cand_time [PAD];
  logic [K_W-1:0]            cand_idx  [PAD];
  logic [RC_W-1:0]           red_count;
  logic [ROW_W-1:0]          clr_row;
  logic [K_W-1:0]            victim;

  // Split the request address
  assign addr_ext = EXT_W'(address) & ((EXT_W'(1) << ADDR_BITS) - EXT_W'(1));
  assign tag_in   = addr_ext[TSHIFT +: TAG_W];
  assign set_in   = addr_ext[OFFSET_BITS +: SET_W] & SET_MASK;
  assign row_in   = ROW_W'(set_in);
  assign now_in   = TIME_BITS'(now_time);

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_q  <= tag_in;
      now_q  <= now_in;
      row_q  <= row_in;
      base_q <= IDX_W'(set_in) * IDX_W'(SET_SIZE);
    end
  end

  // Set row memories: tags, and valid plus access time
  lrut_ram #(
    .WIDTH (SET_SIZE * TAG_W),
    .DEPTH (SET_COUNT)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (row_q),
    .wr_data (tag_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (row_in),
    .rd_data (tag_rdata)
  );

  assign st_waddr = cmd.clr_step ? clr_row : row_q;

  lrut_ram #(
    .WIDTH (SET_SIZE * ST_W),
    .DEPTH (SET_COUNT)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (cmd.commit || cmd.clr_step),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (row_in),
    .rd_data (st_rdata)
  );

  // Find the first valid entry with a matching tag
  always_comb begin
    hit_c      = 1'b0;
    hit_slot_c = '0;
    for (int k = SET_SIZE - 1; k >= 0; k--) begin
      if (st_rdata[k*ST_W + TIME_BITS] && (tag_rdata[k*TAG_W +: TAG_W] == tag_q)) begin
        hit_c      = 1'b1;
        hit_slot_c = K_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_q      <= hit_c;
      hit_slot_q <= hit_slot_c;
    end
  end

  // Oldest-entry search: load times, then halve the candidates each step
  for (genvar gi = 0; gi < PAD; gi++) begin : g_cand
    logic [TIME_BITS-1:0] load_time;
    logic [TIME_BITS-1:0] step_time;
    logic [K_W-1:0]       step_idx;

    if (gi < SET_SIZE) begin : g_real
      assign load_time = st_rdata[gi*ST_W +: TIME_BITS];
    end else begin : g_pad
      assign load_time = '1;
    end

    if (gi < PAD / 2) begin : g_pair
      logic take_right;
      // ties stay with the lower slot
      assign take_right = cand_time[2*gi+1] < cand_time[2*gi];
      assign step_time  = take_right ? cand_time[2*gi+1] : cand_time[2*gi];
      assign step_idx   = take_right ? cand_idx[2*gi+1]  : cand_idx[2*gi];
    end else begin : g_hold
      assign step_time = cand_time[gi];
      assign step_idx  = cand_idx[gi];
    end

    always_ff @(posedge clk) begin
      if (cmd.look) begin
        cand_time[gi] <= load_time;
        cand_idx[gi]  <= K_W'(gi);
      end else if (cmd.reduce_step) begin
        cand_time[gi] <= step_time;
        cand_idx[gi]  <= step_idx;
      end
    end
  end

  // Count search steps
  always_ff @(posedge clk) begin
    if (rst) begin
      red_count <= '0;
    end else if (cmd.look) begin
      red_count <= '0;
    end else if (cmd.reduce_step) begin
      red_count <= red_count + RC_W'(1);
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr_step) begin
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  assign status.look_hit    = hit_c;
  assign status.reduce_last = (LEVELS == 0) || (red_count == RC_W'(LEVELS - 1));
  assign status.clear_last  = (clr_row == ROW_W'(SET_COUNT - 1));

  // Build the write-back rows around the accessed slot
  assign victim = hit_q ? hit_slot_q : cand_idx[0];

  for (genvar gk = 0; gk < SET_SIZE; gk++) begin : g_wr
    assign tag_wdata[gk*TAG_W +: TAG_W] = (victim == K_W'(gk)) ? tag_q
                                          : tag_rdata[gk*TAG_W +: TAG_W];
    assign st_wdata[gk*ST_W +: ST_W] = cmd.clr_step ? '0
                                       : (victim == K_W'(gk)) ? {1'b1, now_q}
                                       : st_rdata[gk*ST_W +: ST_W];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= hit_q;
      entry_index <= IDX_OUT_W'(base_q + IDX_W'(victim));
    end
  end

endmodule

// ----- hw/rtl/lru_set_assoc_tag_store_top.sv -----
`timescale 1ns / 1ps
// Sequence: a hit passes from acceptance through lookup to write-back; a miss also runs
// the halving steps of the search tree before write-back. A new request is taken only when
// idle, after the last one is written back; write-back waits while a result is stalled.
// Reset: a clearing pass over all SET_COUNT rows zeroes valid bits and times;
// in_stall stays high until it ends.
// ----------------------------------------------------------------------------
// LRU set-associative tag store
// Looks up an address in its set, replaces the least recently used entry
// on a miss, and records the request time in the accessed entry.
// ----------------------------------------------------------------------------
module lru_set_assoc_tag_store_top #(
  parameter int ADDR_BITS   = 32,
  parameter int OFFSET_BITS = 2,
  parameter int WAYS        = 4,
  parameter int SET_COUNT   = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    address,
  input  logic [31:0]                    now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [lrut_pkg::IDX_OUT_W-1:0] entry_index
);

  import lrut_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing and handshake
  lrut_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Memories, compare, search and result
  lrut_dp #(
    .ADDR_BITS   (ADDR_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .WAYS        (WAYS),
    .SET_COUNT   (SET_COUNT),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .address     (address),
    .now_time    (now_time),
    .hit         (hit),
    .entry_index (entry_index)
  );

endmodule

// ----- tb/lru_set_assoc_tag_store_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU set-associative tag store testbench
// Drives lookup requests through the valid/stall handshake and checks every
// hit flag and entry index against an in-bench LRU tag store. The sender and
// receiver idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module lru_set_assoc_tag_store_top_test;

  localparam int OFFSET_BITS = 2;
  localparam int WAYS        = 4;
  localparam int SET_COUNT   = 64;
  localparam int SET_BITS    = $clog2(SET_COUNT);
  localparam int SET_SIZE    = WAYS * (1 << OFFSET_BITS);
  localparam int ENTRIES     = SET_COUNT * SET_SIZE;
  localparam int TAG_SHIFT   = OFFSET_BITS + SET_BITS;
  localparam int TAG_W       = 32 - TAG_SHIFT;
  localparam int IDX_W       = lrut_pkg::IDX_OUT_W;
  localparam int LONG_HOLD   = 150;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] now_time;
  } lookup_req_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] entry_index;
  } lookup_res_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [31:0]      address     = '0;
  logic [31:0]      now_time    = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic             hit;
  logic [IDX_W-1:0] entry_index;

  // In-bench copy of the tag store
  logic             line_valid [ENTRIES];
  logic [TAG_W-1:0] line_tag   [ENTRIES];
  logic [31:0]      line_time  [ENTRIES];

  lookup_req_t      req_queue[$];
  lookup_res_t      due_results[$];

  int               send_idle_pct = 0;
  int               rcv_idle_pct  = 0;
  logic             send_pause    = 1'b0;
  int               hold_asks     = 0;
  int               hold_seen     = 0;
  int               hold_left     = 0;
  int               mismatch_count = 0;
  int               result_no     = 0;
  logic [31:0]      clock_stamp   = '0;
  logic [TAG_W-1:0] tag_base      = '0;
  logic [SET_BITS-1:0] hot_set    = '0;

  lru_set_assoc_tag_store_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .address     (address),
    .now_time    (now_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .entry_index (entry_index)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Look up one address, replace the oldest entry on a miss, stamp the time
  function automatic void lru_access(input logic [31:0] addr, input logic [31:0] stamp,
                                     output logic hit_o, output logic [IDX_W-1:0] idx_o);
    logic [TAG_W-1:0] tag_v;
    int               base;
    int               pick;
    logic             found;
    tag_v = TAG_W'(addr >> TAG_SHIFT);
    base  = int'((addr >> OFFSET_BITS) & (SET_COUNT - 1)) * SET_SIZE;
    found = 1'b0;
    pick  = base;
    for (int k = 0; k < SET_SIZE; k++) begin
      if (!found && line_valid[base + k] && line_tag[base + k] == tag_v) begin
        found = 1'b1;
        pick  = base + k;
      end
    end
    if (!found) begin
      for (int k = 1; k < SET_SIZE; k++) begin
        if (line_time[base + k] < line_time[pick]) pick = base + k;
      end
      line_valid[pick] = 1'b1;
      line_tag[pick]   = tag_v;
    end
    line_time[pick] = stamp;
    hit_o = found;
    idx_o = pick[IDX_W-1:0];
  endfunction

  // Mostly a small tag pool over a few sets so that hits and evictions occur
  function automatic lookup_req_t next_request();
    lookup_req_t         r;
    logic [SET_BITS-1:0] set_no;
    logic [TAG_W-1:0]    tag_v;
    int                  roll;
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(3))
        0:       set_no = '0;
        1:       set_no = '1;
        2:       set_no = hot_set;
        default: set_no = SET_BITS'($urandom_range(SET_COUNT - 1));
      endcase
      tag_v     = tag_base ^ TAG_W'($urandom_range(23));
      r.address = (32'(tag_v) << TAG_SHIFT) | (32'(set_no) << OFFSET_BITS)
                  | 32'($urandom_range((1 << OFFSET_BITS) - 1));
    end else begin
      r.address = $urandom;
    end
    roll = $urandom_range(99);
    if (roll < 85) clock_stamp = clock_stamp + 32'($urandom_range(6));
    else if (roll < 93) clock_stamp = $urandom;
    r.now_time = (roll < 97) ? clock_stamp : $urandom;
    return r;
  endfunction

  task automatic queue_request(input logic [31:0] addr, input logic [31:0] stamp);
    lookup_req_t r;
    r.address  = addr;
    r.now_time = stamp;
    req_queue.push_back(r);
  endtask

  // Driver: predict on acceptance, then hold, advance or idle
  always @(posedge clk) begin
    logic             h;
    logic [IDX_W-1:0] ix;
    lookup_req_t      nxt;
    lookup_res_t      w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        lru_access(address, now_time, h, ix);
        w.hit         = h;
        w.entry_index = ix;
        due_results.push_back(w);
      end
      if (!in_valid || !in_stall) begin
        if (!send_pause && req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_queue.pop_front();
          address  <= nxt.address;
          now_time <= nxt.now_time;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result and drive the receiver stall
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_no++;
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d with no request pending: hit %0b index %0d",
                     result_no, hit, entry_index);
        end else begin
          want = due_results.pop_front();
          if (hit !== want.hit || entry_index !== want.entry_index) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected hit %0b index %0d, got hit %0b index %0d",
                       result_no, want.hit, want.entry_index, hit, entry_index);
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    for (int e = 0; e < ENTRIES; e++) begin
      line_valid[e] = 1'b0;
      line_time[e]  = '0;
    end
    tag_base = TAG_W'($urandom);
    hot_set  = SET_BITS'($urandom_range(SET_COUNT - 1));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 86 : 0;
      rcv_idle_pct  = (phase == 0) ? 86 : (phase == 1) ? 23 : 0;
      if (phase == 0) begin
        // Empty store, offset ignored, all-ones address and time
        queue_request(32'h0000_0000, 32'h0000_0000);
        queue_request(32'h0000_0003, 32'd5);
        queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(32'hFFFF_FFFC, 32'd1);
        queue_request(32'h0000_0100, 32'd2);
        // Fill set zero; equal zero times go to the lowest slot
        for (int t = 2; t < SET_SIZE; t++)
          queue_request(32'(t) << TAG_SHIFT, 32'(10 + t));
        // Evict the oldest, hit the first, evict again
        queue_request(32'(SET_SIZE) << TAG_SHIFT, 32'd30);
        queue_request(32'h0000_0001, 32'd31);
        queue_request(32'h0000_0100, 32'd32);
      end
      for (int n = 0; n < ((phase == 2) ? 340 : 330); n++)
        req_queue.push_back(next_request());
      if (phase == 2) begin
        // Long receiver hold while the sender keeps offering
        hold_asks = hold_asks + 1;
        while (req_queue.size() > 170) @(negedge clk);
        // Sender pause until every pending result has come back
        send_pause = 1'b1;
        while (in_valid || due_results.size() != 0) @(negedge clk);
        send_pause = 1'b0;
      end
      while (req_queue.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("** lru_set_assoc_tag_store_top: PASSED **");
    end else begin
      $display("** lru_set_assoc_tag_store_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("** lru_set_assoc_tag_store_top: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lrut_pkg.sv
hw/rtl/lrut_ram.sv
hw/rtl/lrut_ctrl.sv
hw/rtl/lrut_dp.sv
hw/rtl/lru_set_assoc_tag_store_top.sv
tb/lru_set_assoc_tag_store_top_test.sv
